FILE: sv/ceadsr_pkg.sv
// Shared types and constants for the cosine ADSR envelope.
package ceadsr_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_W  = 22;
  localparam int IDX_W  = 2;
  localparam int FRAC_W = 12;

  localparam logic [DATA_W-1:0] ATTACK_GAIN = 16'd45875;

  localparam logic [CFG_W-1:0] ATTACK_RESET  = 22'd480;
  localparam logic [CFG_W-1:0] DECAY_RESET   = 22'd2400;
  localparam logic [CFG_W-1:0] RELEASE_RESET = 22'd12000;

  typedef enum logic [IDX_W-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_RELEASE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_ON       = 2'd1,
    MODE_OFF      = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STG_OFF     = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_t;

  typedef struct packed {
    logic load;
    logic set_target;
    logic enter;
    logic rd_a;
    logic rd_b;
    logic interp;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       vel_zero;
    logic       ramp_active;
    logic       len_zero;
    logic       ent_attack;
    logic       div_done;
    logic       out_free;
    logic       emit_to_decay;
  } status_t;

endpackage

FILE: sv/ceadsr_in_if.sv
// Input channel: mode, velocity and pressure word.
interface ceadsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] velocity;
  logic [15:0] pressure;

  modport source (output valid, output mode, output velocity, output pressure, input ready);
  modport sink (input valid, input mode, input velocity, input pressure, output ready);
endinterface

FILE: sv/ceadsr_out_if.sv
// Output channel: amplitude word.
interface ceadsr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] amplitude;

  modport source (output valid, output amplitude, input ready);
  modport sink (input valid, input amplitude, output ready);
endinterface

FILE: sv/cosine_adsr_envelope.sv
// Top level of the cosine ADSR envelope generator.
// A sample tick in sustain or off goes straight to the output register; during a ramp it first
// passes through the two table reads, interpolation and scaling. A note-on with nonzero velocity or a
// note-off, and a tick that ends the attack, also enter a stage; one of nonzero length waits
// for the bit-serial divider that forms the phase increment, and a zero-length attack adds
// another pass through the enter state. The output register lets a new word enter while the
// previous amplitude waits.
module cosine_adsr_envelope import ceadsr_pkg::*; #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  ceadsr_in_if.sink         in_ch,
  ceadsr_out_if.source      out_ch
);

  cmd_t    cmd;
  status_t status;

  ceadsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ceadsr_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .word_mode     (in_ch.mode),
    .word_velocity (in_ch.velocity),
    .word_pressure (in_ch.pressure),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .amplitude     (out_ch.amplitude),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

FILE: sv/ceadsr_div.sv
// Restoring divider for the ramp phase increment, one quotient bit per cycle.
module ceadsr_div import ceadsr_pkg::*; #(
  parameter int PW = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PW-1:0]     dividend,
  input  logic [CFG_W-1:0]  divisor,
  output logic              done,
  output logic [PW-1:0]     quotient
);

  localparam int CW = $clog2(PW + 1);

  logic [CFG_W:0]   rem;
  logic [PW-1:0]    num;
  logic [CFG_W-1:0] den;
  logic [CW-1:0]    count;
  logic             busy;
  logic [CFG_W+1:0] trial;
  logic             fits;

  always_comb begin
    trial = {rem, num[PW-1]};
    fits  = trial >= {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(PW);
        rem   <= '0;
        num   <= dividend;
        den   <= divisor;
      end else if (busy) begin
        rem      <= fits ? (CFG_W+1)'(trial - {2'b00, den}) : trial[CFG_W:0];
        num      <= {num[PW-2:0], 1'b0};
        quotient <= {quotient[PW-2:0], fits};
        count    <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/ceadsr_datapath.sv
// Envelope datapath: state registers, ramp table, interpolation and output register.
module ceadsr_datapath import ceadsr_pkg::*; #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        word_mode,
  input  logic [DATA_W-1:0] word_velocity,
  input  logic [DATA_W-1:0] word_pressure,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] amplitude,
  input  cmd_t              cmd,
  output status_t           status
);

  localparam int HALF_TABLE = TABLE_SIZE / 2;
  localparam int PHASE_END_I = HALF_TABLE * (2 ** FRAC_W);
  localparam int PW = $clog2(PHASE_END_I + 1);
  localparam int IW = $clog2(HALF_TABLE + 1);
  localparam int XW = PW - FRAC_W;
  localparam logic [PW-1:0] PHASE_END = PW'(PHASE_END_I);
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [16:0] wtab_t [HALF_TABLE+1];

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [16:0] half_versine(input int k);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] s;
    t = (PI_Q30 * 64'(k)) / HALF_TABLE;
    u = mul_q30(t, t);
    r = 64'd296;
    r = 64'd26630 - mul_q30(u, r);
    r = 64'd1491308 - mul_q30(u, r);
    r = 64'd44739243 - mul_q30(u, r);
    r = 64'd536870912 - mul_q30(u, r);
    r = mul_q30(u, r);
    s = (r + 64'd16384) >> 15;
    return s[16:0];
  endfunction

  function automatic wtab_t build_tab();
    wtab_t tab;
    for (int k = 0; k <= HALF_TABLE; k++) begin
      if (2 * k <= HALF_TABLE) tab[k] = half_versine(k);
      else tab[k] = 17'd65536 - half_versine(HALF_TABLE - k);
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_tab();

  logic [CFG_W-1:0]  attack_samples;
  logic [CFG_W-1:0]  decay_samples;
  logic [CFG_W-1:0]  release_samples;
  stage_t            env_stage;
  stage_t            ent_stage;
  logic [DATA_W-1:0] ent_target;
  logic [PW-1:0]     ramp_phase;
  logic [PW-1:0]     ramp_step;
  logic [DATA_W-1:0] ramp_base;
  logic [DATA_W-1:0] ramp_height;
  logic              ramp_rising;
  logic [CFG_W-1:0]  stage_counter;
  logic [DATA_W-1:0] last_output;
  logic [DATA_W-1:0] held_pressure;
  logic [1:0]        mode;
  logic [DATA_W-1:0] velocity;
  logic [16:0]       rom_q;
  logic [16:0]       wa;
  logic [16:0]       w;
  logic [DATA_W-1:0] part;

  logic [IW-1:0]     rom_addr;
  logic [XW-1:0]     idx;
  logic              sat;
  logic [CFG_W-1:0]  len;
  logic [CFG_W-1:0]  cnt_dec;
  logic [DATA_W-1:0] amp;
  logic [PW:0]       phase_sum;
  logic [28:0]       lerp;
  logic [33:0]       scaled;
  logic [32:0]       tgt_prod;
  logic              div_done;
  logic [PW-1:0]     quotient;
  logic              ramp_active;

  always_comb begin
    idx         = ramp_phase[PW-1:FRAC_W];
    sat         = 32'(idx) >= HALF_TABLE;
    ramp_active = env_stage == STG_ATTACK || env_stage == STG_DECAY ||
                  env_stage == STG_RELEASE;
    rom_addr    = '0;
    if (!sat) begin
      if (cmd.rd_b) rom_addr = IW'(idx) + 1'b1;
      else rom_addr = IW'(idx);
    end
    unique case (ent_stage)
      STG_ATTACK: len = attack_samples;
      STG_DECAY:  len = decay_samples;
      default:    len = release_samples;
    endcase
    cnt_dec   = (stage_counter == '0) ? '0 : stage_counter - 1'b1;
    lerp      = 29'(rom_q - wa) * 29'(ramp_phase[FRAC_W-1:0]);
    scaled    = 34'(ramp_height) * 34'(w) + 34'd32768;
    tgt_prod  = 33'(velocity) * 33'(ATTACK_GAIN) + 33'd32768;
    phase_sum = {1'b0, ramp_phase} + {1'b0, ramp_step};
    if (ramp_active) begin
      amp = ramp_rising ? ramp_base + part : ramp_base + ramp_height - part;
    end else if (env_stage == STG_SUSTAIN) begin
      amp = held_pressure;
    end else begin
      amp = '0;
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= WTAB[rom_addr];
  end

  ceadsr_div #(.PW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.enter && len != '0),
    .dividend (PHASE_END),
    .divisor  (len),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= ATTACK_RESET;
      decay_samples   <= DECAY_RESET;
      release_samples <= RELEASE_RESET;
      env_stage       <= STG_OFF;
      ent_stage       <= STG_OFF;
      ramp_phase      <= '0;
      ramp_step       <= '0;
      ramp_base       <= '0;
      ramp_height     <= '0;
      ramp_rising     <= 1'b0;
      stage_counter   <= '0;
      last_output     <= '0;
      held_pressure   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ATTACK:  attack_samples  <= cfg_data;
          REG_DECAY:   decay_samples   <= cfg_data;
          REG_RELEASE: release_samples <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        mode     <= word_mode;
        velocity <= word_velocity;
        if (word_mode != MODE_RESERVED) held_pressure <= word_pressure;
      end
      if (cmd.set_target) begin
        if (mode == MODE_ON) begin
          ent_stage  <= STG_ATTACK;
          ent_target <= tgt_prod[31:16];
        end else begin
          ent_stage  <= STG_RELEASE;
          ent_target <= '0;
        end
      end
      if (cmd.enter) begin
        if (len == '0) begin
          last_output <= ent_target;
          if (ent_stage == STG_ATTACK) begin
            ent_stage  <= STG_DECAY;
            ent_target <= held_pressure;
          end else begin
            env_stage <= (ent_stage == STG_DECAY) ? STG_SUSTAIN : STG_OFF;
          end
        end else begin
          env_stage <= ent_stage;
          if (ent_target > last_output) begin
            ramp_base   <= last_output;
            ramp_height <= ent_target - last_output;
            ramp_rising <= 1'b1;
          end else begin
            ramp_base   <= ent_target;
            ramp_height <= last_output - ent_target;
            ramp_rising <= 1'b0;
          end
          ramp_phase    <= '0;
          stage_counter <= len;
        end
      end
      if (div_done) ramp_step <= quotient;
      if (cmd.rd_b) wa <= rom_q;
      if (cmd.interp) w <= sat ? 17'd65536 : wa + 17'(lerp >> FRAC_W);
      if (cmd.scale) part <= scaled[31:16];
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        amplitude   <= amp;
        last_output <= amp;
        if (ramp_active) begin
          ramp_phase    <= (phase_sum > {1'b0, PHASE_END}) ? PHASE_END : phase_sum[PW-1:0];
          stage_counter <= cnt_dec;
          if (cnt_dec == '0) begin
            unique case (env_stage)
              STG_ATTACK: begin
                ent_stage  <= STG_DECAY;
                ent_target <= held_pressure;
              end
              STG_DECAY: env_stage <= STG_SUSTAIN;
              default:   env_stage <= STG_OFF;
            endcase
          end
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.mode          = mode;
    status.vel_zero      = velocity == '0;
    status.ramp_active   = ramp_active;
    status.len_zero      = len == '0;
    status.ent_attack    = ent_stage == STG_ATTACK;
    status.div_done      = div_done;
    status.out_free      = !out_valid || out_ready;
    status.emit_to_decay = ramp_active && env_stage == STG_ATTACK && cnt_dec == '0;
  end

endmodule

FILE: sv/ceadsr_ctrl.sv
// Envelope sequencer: steps the datapath through one input word.
module ceadsr_ctrl import ceadsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ENTER, S_DIV, S_RDA, S_RDB, S_INTERP, S_SCALE, S_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    in_ready       = state == S_IDLE;
    cmd.load       = state == S_IDLE && in_valid;
    cmd.set_target = state == S_DISP;
    cmd.enter      = state == S_ENTER;
    cmd.rd_a       = state == S_RDA;
    cmd.rd_b       = state == S_RDB;
    cmd.interp     = state == S_INTERP;
    cmd.scale      = state == S_SCALE;
    cmd.emit       = state == S_EMIT && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DISP;
        S_DISP: begin
          priority if (status.mode == MODE_TICK) begin
            state <= status.ramp_active ? S_RDA : S_EMIT;
          end else if (status.mode == MODE_ON) begin
            state <= status.vel_zero ? S_IDLE : S_ENTER;
          end else if (status.mode == MODE_OFF) begin
            state <= S_ENTER;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ENTER: begin
          priority if (!status.len_zero) state <= S_DIV;
          else if (status.ent_attack) state <= S_ENTER;
          else state <= S_IDLE;
        end
        S_DIV:    if (status.div_done) state <= S_IDLE;
        S_RDA:    state <= S_RDB;
        S_RDB:    state <= S_INTERP;
        S_INTERP: state <= S_SCALE;
        S_SCALE:  state <= S_EMIT;
        S_EMIT: begin
          if (status.out_free) state <= status.emit_to_decay ? S_ENTER : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb_cosine_adsr_envelope.sv
// Testbench for the cosine ADSR envelope: directed and random input words checked against a predictor.
module tb_cosine_adsr_envelope;
  import ceadsr_pkg::*;

  localparam int HALF = 512;
  localparam int unsigned PHASE_END = HALF << FRAC_W;

  class envelope_scoreboard;
    int unsigned wtab[0:HALF];
    int unsigned len_attack, len_decay, len_release;
    stage_t stage;
    int unsigned phase, step, base, height, rising, counter, last_amp, held;
    logic [DATA_W-1:0] amp_q[$];
    int errors, ticks, notes;

    function longint unsigned mq(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
    endfunction

    function int unsigned versine(int unsigned k);
      longint unsigned t, u, r;
      t = (64'd3373259426 * k) / HALF;
      u = mq(t, t);
      r = 296;
      r = 26630 - mq(u, r);
      r = 1491308 - mq(u, r);
      r = 44739243 - mq(u, r);
      r = 536870912 - mq(u, r);
      r = mq(u, r);
      return int'((r + (1 << 14)) >> 15);
    endfunction

    function new();
      for (int k = 0; k <= HALF; k++) begin
        if (2 * k <= HALF) wtab[k] = versine(k);
        else wtab[k] = 65536 - versine(HALF - k);
      end
      len_attack = ATTACK_RESET;
      len_decay = DECAY_RESET;
      len_release = RELEASE_RESET;
      stage = STG_OFF;
      phase = 0; step = 0; base = 0; height = 0; rising = 0;
      counter = 0; last_amp = 0; held = 0;
      errors = 0; ticks = 0; notes = 0;
    endfunction

    function void write_reg(reg_idx_t idx, int unsigned v);
      case (idx)
        REG_ATTACK: len_attack = v;
        REG_DECAY: len_decay = v;
        REG_RELEASE: len_release = v;
        default: ;
      endcase
    endfunction

    function int unsigned ramp_out();
      int unsigned idx, w, part;
      idx = phase >> FRAC_W;
      if (idx >= HALF) w = 65536;
      else w = wtab[idx] + (((wtab[idx+1] - wtab[idx]) * (phase & 4095)) >> FRAC_W);
      part = int'(((longint'(height) * w) + 32768) >> 16);
      return rising ? base + part : base + height - part;
    endfunction

    function void enter(stage_t st, int unsigned target);
      int unsigned len;
      forever begin
        len = (st == STG_ATTACK) ? len_attack : (st == STG_DECAY) ? len_decay : len_release;
        if (len == 0) begin
          last_amp = target;
          if (st == STG_ATTACK) begin
            st = STG_DECAY;
            target = held;
            continue;
          end
          stage = (st == STG_DECAY) ? STG_SUSTAIN : STG_OFF;
          return;
        end
        stage = st;
        if (target > last_amp) begin
          base = last_amp; height = target - last_amp; rising = 1;
        end else begin
          base = target; height = last_amp - target; rising = 0;
        end
        phase = 0;
        step = PHASE_END / len;
        counter = len;
        return;
      end
    endfunction

    function void note_word(logic [1:0] m, logic [15:0] vel, logic [15:0] pr);
      int unsigned amp;
      if (m == MODE_RESERVED) return;
      held = pr;
      if (m == MODE_ON) begin
        notes++;
        if (vel != 0) enter(STG_ATTACK, (vel * 45875 + 32768) >> 16);
        return;
      end
      if (m == MODE_OFF) begin
        notes++;
        enter(STG_RELEASE, 0);
        return;
      end
      ticks++;
      if (stage == STG_ATTACK || stage == STG_DECAY || stage == STG_RELEASE) begin
        amp = ramp_out();
        phase += step;
        if (phase > PHASE_END) phase = PHASE_END;
        last_amp = amp;
        if (counter > 0) counter--;
        if (counter == 0) begin
          if (stage == STG_ATTACK) enter(STG_DECAY, held);
          else if (stage == STG_DECAY) stage = STG_SUSTAIN;
          else stage = STG_OFF;
        end
      end else if (stage == STG_SUSTAIN) begin
        amp = held;
        last_amp = amp;
      end else begin
        amp = 0;
        last_amp = 0;
      end
      amp_q.push_back(amp[15:0]);
    endfunction

    function void check_word(logic [15:0] amp);
      logic [15:0] exp_amp;
      if (amp_q.size() == 0) begin
        $error("unexpected amplitude word %0d", amp);
        errors++;
        return;
      end
      exp_amp = amp_q.pop_front();
      if (amp !== exp_amp) begin
        $error("amplitude: expected %0d, actual %0d", exp_amp, amp);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int snd_idle = 0;
  int rcv_idle = 0;
  envelope_scoreboard sb = new();

  ceadsr_in_if in_ch();
  ceadsr_out_if out_ch();

  cosine_adsr_envelope dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_word(out_ch.amplitude);
  end

  task automatic send_word(logic [1:0] m, logic [15:0] vel, logic [15:0] pr);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.velocity <= vel;
    in_ch.pressure <= pr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(m, vel, pr);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.amp_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  function automatic int unsigned pick_len(int ph);
    int r;
    r = $urandom_range(0, 99);
    if (ph == 5 && r < 30) return 22'h3FFFFF;
    if (r < 20) return 0;
    if (r < 90) return $urandom_range(1, 8);
    return $urandom_range(9, 60);
  endfunction

  task automatic random_word();
    int r;
    logic [15:0] vel;
    r = $urandom_range(0, 99);
    vel = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
    if (r < 72) send_word(MODE_TICK, 16'($urandom), 16'($urandom));
    else if (r < 86) send_word(MODE_ON, vel, 16'($urandom));
    else if (r < 96) send_word(MODE_OFF, 16'($urandom), 16'($urandom));
    else send_word(MODE_RESERVED, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.velocity = '0;
    in_ch.pressure = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    snd_idle = 15;
    rcv_idle = 54;

    send_word(MODE_TICK, 16'hFFFF, 16'h0000);
    send_word(MODE_OFF, 16'h0000, 16'hFFFF);
    send_word(MODE_TICK, 16'h0000, 16'hFFFF);
    send_word(MODE_ON, 16'h0000, 16'h1234);
    send_word(MODE_RESERVED, 16'hFFFF, 16'hFFFF);
    send_word(MODE_ON, 16'hFFFF, 16'hFFFF);
    repeat (4) send_word(MODE_TICK, 16'h0000, 16'h8000);
    drain();
    write_reg(REG_ATTACK, 0);
    write_reg(REG_DECAY, 0);
    write_reg(REG_RELEASE, 22'h3FFFFF);
    send_word(MODE_ON, 16'hFFFF, 16'hFFFF);
    send_word(MODE_TICK, 16'h0000, 16'h0000);
    send_word(MODE_OFF, 16'h0000, 16'h4000);
    repeat (3) send_word(MODE_TICK, 16'h0000, 16'hFFFF);
    drain();
    write_reg(REG_ATTACK, 1);
    write_reg(REG_DECAY, 2);
    write_reg(REG_RELEASE, 0);
    send_word(MODE_ON, 16'h0001, 16'hFFFF);
    repeat (4) send_word(MODE_TICK, 16'h0000, 16'h7FFF);
    send_word(MODE_OFF, 16'h0000, 16'h0000);
    send_word(MODE_TICK, 16'h0000, 16'h0000);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      snd_idle = (ph < 2) ? 15 : (ph < 4) ? 54 : 0;
      rcv_idle = (ph < 2) ? 54 : (ph < 4) ? 15 : 0;
      write_reg(REG_ATTACK, pick_len(ph));
      write_reg(REG_DECAY, pick_len(ph));
      write_reg(REG_RELEASE, pick_len(ph));
      repeat (120) random_word();
    end

    drain();
    $display("covered %0d sample ticks and %0d note words over six register settings",
             sb.ticks, sb.notes);
    if (sb.errors == 0 && sb.amp_q.size() == 0) begin
      $display("tb_cosine_adsr_envelope passed");
    end else begin
      $display("tb_cosine_adsr_envelope failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_cosine_adsr_envelope failed");
    $finish;
  end
endmodule
